### rtl/core/tas_pkg.sv
// Shared types, constants and decode helpers for the timed action sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tas_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam int KIND_W  = 5;
	localparam int TICKS_W = 16;
	localparam int PARAM_W = 16;
	localparam int CB_W    = 8;
	localparam int MSG_W   = 8;
	localparam int BUSY_W  = 8;
	localparam int OP_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
	localparam logic [OP_W-1:0] OP_POLL = 2'd1;
	localparam logic [OP_W-1:0] OP_FIN  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_MSG   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVER_MSG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS = 2'd2;

	// action type codes
	localparam logic [KIND_W-1:0] KIND_LED  = 5'd18;
	localparam logic [KIND_W-1:0] KIND_MISC = 5'd19;

	// group bits
	localparam logic [BUSY_W-1:0] GRP_MOTOR1 = 8'h80;
	localparam logic [BUSY_W-1:0] GRP_LED    = 8'h02;
	localparam logic [BUSY_W-1:0] GRP_MISC   = 8'h01;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [TICKS_W-1:0] ticks;
		logic [PARAM_W-1:0] param;
		logic [CB_W-1:0]    cb;
	} act_rec_t;

	typedef struct packed {
		logic     empty;
		logic     accepted;
		act_rec_t head;
	} store_stat_t;

	typedef struct packed {
		logic [MSG_W-1:0]   step_msg;
		logic [MSG_W-1:0]   over_msg;
		logic [TICKS_W-1:0] idle_ticks;
	} cfg_t;

	function automatic logic [BUSY_W-1:0] group_bit(input logic [KIND_W-1:0] kind);
		logic [BUSY_W-1:0] bit_v;
		bit_v = '0;
		case (kind) inside
			[5'd0:5'd2]:   bit_v = GRP_MOTOR1;
			[5'd3:5'd5]:   bit_v = GRP_MOTOR1 >> 1;
			[5'd6:5'd8]:   bit_v = GRP_MOTOR1 >> 2;
			[5'd9:5'd11]:  bit_v = GRP_MOTOR1 >> 3;
			[5'd12:5'd14]: bit_v = GRP_MOTOR1 >> 4;
			[5'd15:5'd17]: bit_v = GRP_MOTOR1 >> 5;
			KIND_LED:      bit_v = GRP_LED;
			KIND_MISC:     bit_v = GRP_MISC;
			default:       bit_v = '0;
		endcase
		return bit_v;
	endfunction

endpackage

`default_nettype wire

### rtl/core/timed_action_sequencer.sv
// Top level of the timed action sequencer: configuration registers and the
// wiring of the action store and the launch logic. Depends on tas_pkg,
// tas_store and tas_launch.
//
//   channel   handshake             payload
//   --------  --------------------  ------------------------------------------
//   command   start, busy           op, action_type, action_time,
//                                   action_param, callback_id
//   result    done (one-cycle)      accepted, started, started_type,
//                                   started_param, started_callback,
//                                   call_callback, busy_bits, timer_load,
//                                   timer_ticks, timer_msg
//   config    cfg_we                cfg_index, cfg_data
//
// In a transaction the store memory is read at the accept edge, the result is
// decoded from the read data and registered at the next edge, and done is
// high in the cycle after that. busy is high for the one cycle in between,
// so a new transaction may start in the cycle done is high.
// Reset empties the queue and clears the busy group; no clearing pass.
// The receiver cannot stall; done is never held and nothing else stalls.
`default_nettype none

module timed_action_sequencer
	import tas_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [OP_W-1:0]       op,
	input  wire logic [KIND_W-1:0]     action_type,
	input  wire logic [TICKS_W-1:0]    action_time,
	input  wire logic [PARAM_W-1:0]    action_param,
	input  wire logic [CB_W-1:0]       callback_id,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       done,
	output logic                       accepted,
	output logic                       started,
	output logic [KIND_W-1:0]          started_type,
	output logic [PARAM_W-1:0]         started_param,
	output logic [CB_W-1:0]            started_callback,
	output logic                       call_callback,
	output logic [BUSY_W-1:0]          busy_bits,
	output logic                       timer_load,
	output logic [TICKS_W-1:0]         timer_ticks,
	output logic [MSG_W-1:0]           timer_msg
);

	cfg_t         cfg_q;
	act_rec_t     wr_action;
	store_stat_t  stat;
	logic         take;
	logic         pop;
	logic         pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_msg   <= '0;
			cfg_q.over_msg   <= '0;
			cfg_q.idle_ticks <= TICKS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEP_MSG:   cfg_q.step_msg   <= cfg_data[MSG_W-1:0];
				CFG_OVER_MSG:   cfg_q.over_msg   <= cfg_data[MSG_W-1:0];
				CFG_IDLE_TICKS: cfg_q.idle_ticks <= cfg_data[TICKS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign busy = pending;
	assign take = start && !pending;

	assign wr_action.kind  = action_type;
	assign wr_action.ticks = action_time;
	assign wr_action.param = action_param;
	assign wr_action.cb    = callback_id;

	tas_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.op        (op),
		.wr_action (wr_action),
		.pop       (pop),
		.stat      (stat)
	);

	tas_launch u_launch (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.op               (op),
		.stat             (stat),
		.cfg              (cfg_q),
		.pop              (pop),
		.pending          (pending),
		.done             (done),
		.accepted         (accepted),
		.started          (started),
		.started_type     (started_type),
		.started_param    (started_param),
		.started_callback (started_callback),
		.call_callback    (call_callback),
		.busy_bits        (busy_bits),
		.timer_load       (timer_load),
		.timer_ticks      (timer_ticks),
		.timer_msg        (timer_msg)
	);

endmodule

`default_nettype wire

### rtl/core/tas_store.sv
// Ring store of queued actions: action memory, read and write indexes.
// Depends on tas_pkg.
`default_nettype none

module tas_store
	import tas_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [OP_W-1:0]   op,
	input  wire act_rec_t          wr_action,
	input  wire logic              pop,
	output store_stat_t            stat
);

	act_rec_t           mem [QUEUE_DEPTH];
	logic [IDX_W-1:0]   rd_idx_q;
	logic [IDX_W-1:0]   wr_idx_q;
	logic [IDX_W-1:0]   wr_nxt;
	logic [IDX_W-1:0]   rd_nxt;
	logic               full;
	logic               do_write;
	act_rec_t           head_s1;
	logic               empty_s1;
	logic               acc_s1;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] n;
		if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = i + IDX_W'(1);
		end
		return n;
	endfunction

	assign wr_nxt   = next_idx(wr_idx_q);
	assign rd_nxt   = next_idx(rd_idx_q);
	assign full     = (wr_nxt == rd_idx_q);
	assign do_write = take && (op == OP_ENQ) && !full;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_idx_q] <= wr_action;
		end
		if (take) begin
			head_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			empty_s1 <= 1'b1;
			acc_s1   <= 1'b0;
		end else begin
			if (do_write) begin
				wr_idx_q <= wr_nxt;
			end
			if (pop) begin
				rd_idx_q <= rd_nxt;
			end
			if (take) begin
				empty_s1 <= (rd_idx_q == wr_idx_q);
				acc_s1   <= do_write;
			end
		end
	end

	assign stat.empty    = empty_s1;
	assign stat.accepted = acc_s1;
	assign stat.head     = head_s1;

endmodule

`default_nettype wire

### rtl/core/tas_launch.sv
// Item decode, busy group register and registered result fields.
// Depends on tas_pkg; reads the head entry delivered by tas_store.
`default_nettype none

module tas_launch
	import tas_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [OP_W-1:0]     op,
	input  wire store_stat_t         stat,
	input  wire cfg_t                cfg,
	output logic                     pop,
	output logic                     pending,
	output logic                     done,
	output logic                     accepted,
	output logic                     started,
	output logic [KIND_W-1:0]        started_type,
	output logic [PARAM_W-1:0]       started_param,
	output logic [CB_W-1:0]          started_callback,
	output logic                     call_callback,
	output logic [BUSY_W-1:0]        busy_bits,
	output logic                     timer_load,
	output logic [TICKS_W-1:0]       timer_ticks,
	output logic [MSG_W-1:0]         timer_msg
);

	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [BUSY_W-1:0]  busy_q;
	logic [BUSY_W-1:0]  busy_nxt;
	logic [BUSY_W-1:0]  grp;
	logic               launch;
	logic               idle_load;

	assign grp = group_bit(stat.head.kind);

	always_comb begin
		launch    = 1'b0;
		idle_load = 1'b0;
		busy_nxt  = busy_q;
		if (valid_s1) begin
			unique case (op_s1)
				OP_POLL: begin
					launch = (busy_q == '0) && !stat.empty;
					if (launch) begin
						busy_nxt = grp;
					end
				end
				OP_FIN: begin
					launch    = !stat.empty;
					idle_load = stat.empty;
					busy_nxt  = launch ? grp : '0;
				end
				default: begin
					launch = 1'b0;
				end
			endcase
		end
	end

	assign pop     = launch;
	assign pending = valid_s1;

	always_ff @(posedge clk) begin
		started_type     <= launch ? stat.head.kind : '0;
		started_param    <= launch ? stat.head.param : '0;
		started_callback <= launch ? stat.head.cb : '0;
		call_callback    <= launch && (grp != '0) && (stat.head.cb != '0);
		started          <= launch;
		accepted         <= stat.accepted;
		timer_load       <= launch || idle_load;
		if (launch) begin
			timer_ticks <= stat.head.ticks;
			timer_msg   <= cfg.step_msg;
		end else if (idle_load) begin
			timer_ticks <= cfg.idle_ticks;
			timer_msg   <= cfg.over_msg;
		end else begin
			timer_ticks <= '0;
			timer_msg   <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= OP_ENQ;
			busy_q   <= '0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (take) begin
				op_s1 <= op;
			end
			busy_q <= busy_nxt;
			done   <= valid_s1;
		end
	end

	assign busy_bits = busy_q;

endmodule

`default_nettype wire
